FILE: src/assert_macros.svh
// Assertion macros for the chained hash map RTL.
// Used by the top level; expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock while out of reset.
`define CHM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock, reset included.
`define CHM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/chm_pkg.sv
// Package for the chained hash map: sizes, hash constants, payload and store types.
// No dependencies.
`timescale 1ns / 1ps
package chm_pkg;

  // Bucket count must be a power of two.
  localparam int BUCKETS = 512;
  localparam int CAP     = 512;

  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int SLOT_W  = $clog2(CAP);
  localparam int IDX_W   = $clog2(CAP + 1);
  localparam int TOTAL_W = 10;
  localparam int CLR_MAX = (BUCKETS > CAP) ? BUCKETS : CAP;
  localparam int CLR_W   = $clog2(CLR_MAX);

  localparam logic [63:0] FNV_OFFSET   = 64'hcbf29ce484222325;
  localparam int          PRIME_SHIFT  = 40;
  localparam logic [8:0]  PRIME_LO     = 9'h1b3;
  localparam int          HASH_ROUNDS  = 8;

  localparam logic [IDX_W-1:0] NO_ENTRY = IDX_W'(CAP);

  localparam logic [1:0] MODE_GET    = 2'd0;
  localparam logic [1:0] MODE_PUT    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [63:0]        old_value;
    logic               status;
    logic [TOTAL_W-1:0] entry_total;
  } rsp_t;

  typedef struct packed {
    logic              head_we;
    logic [BKT_W-1:0]  head_waddr;
    logic [IDX_W-1:0]  head_wdata;
    logic [BKT_W-1:0]  head_raddr;
    logic              key_we;
    logic              val_we;
    logic              link_we;
    logic [SLOT_W-1:0] ent_waddr;
    logic [63:0]       ent_key;
    logic [63:0]       ent_val;
    logic [IDX_W-1:0]  ent_link;
    logic [SLOT_W-1:0] ent_raddr;
    logic              free_we;
    logic [SLOT_W-1:0] free_waddr;
    logic [SLOT_W-1:0] free_wdata;
    logic [SLOT_W-1:0] free_raddr;
  } store_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  head;
    logic [63:0]       key;
    logic [63:0]       val;
    logic [IDX_W-1:0]  link;
    logic [SLOT_W-1:0] free;
  } store_rd_t;

endpackage

FILE: src/chained_hash_map_unit.sv
// Top level of the chained hash map: request sequencer, chain walk and result register.
// Depends on chm_pkg, chm_hash, chm_store and assert_macros.svh.
//
//  channel | signals                  | word
//  req     | req_valid, req_ready     | mode, key, value
//  rsp     | rsp_valid, rsp_ready     | found, old_value, status, entry_total
//
// Each request is hashed by the eight rounds of the hash unit, then walks the chain
// of its bucket over the entry memories, one entry at a time; a put of a new key
// also takes a slot from the free stack. A request that is not a valid mode skips
// the hash and the walk. After reset, a clearing pass sets the bucket heads empty
// and refills the free stack; req_ready stays low during it. A stalled rsp holds
// its word; one new request may be taken while it waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module chained_hash_map_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  chm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output chm_pkg::rsp_t rsp
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_HEADW, S_WALK, S_CMP, S_ACT, S_POP, S_DONE
  } state_t;

  state_t                       state;
  logic [chm_pkg::CLR_W-1:0]    clr;
  chm_pkg::req_t                req_q;
  logic [chm_pkg::IDX_W-1:0]    cur;
  logic [chm_pkg::IDX_W-1:0]    prev;
  logic [chm_pkg::IDX_W-1:0]    steps;
  logic [chm_pkg::IDX_W-1:0]    hit;
  logic [chm_pkg::IDX_W-1:0]    link_e;
  logic [chm_pkg::IDX_W-1:0]    head_val;
  logic                         found_q;
  logic [63:0]                  old_q;
  logic                         status_q;
  logic [chm_pkg::IDX_W-1:0]    free_count;
  logic [chm_pkg::IDX_W-1:0]    key_count;
  logic                         hash_start;
  logic                         hash_done;
  logic [chm_pkg::BKT_W-1:0]    bucket;
  logic [chm_pkg::BKT_W-1:0]    bucket_q;
  chm_pkg::store_cmd_t          cmd;
  chm_pkg::store_rd_t           rd;
  logic                         accept;
  logic                         rsp_free;

  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign rsp_free   = !rsp_valid || rsp_ready;
  assign hash_start = accept && (req.mode <= chm_pkg::MODE_REMOVE);

  chm_hash u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .key    (req.key),
    .done   (hash_done),
    .bucket (bucket)
  );

  chm_store u_store (
    .clk (clk),
    .cmd (cmd),
    .rd  (rd)
  );

  always_comb begin
    cmd            = '0;
    cmd.head_raddr = bucket_q;
    cmd.ent_raddr  = cur[chm_pkg::SLOT_W-1:0];
    cmd.free_raddr = chm_pkg::SLOT_W'(free_count - 1'b1);
    cmd.ent_key    = req_q.key;
    cmd.ent_val    = req_q.value;
    case (state)
      S_CLEAR: begin
        cmd.head_we    = ({1'b0, clr} < (chm_pkg::CLR_W + 1)'(chm_pkg::BUCKETS));
        cmd.head_waddr = chm_pkg::BKT_W'(clr);
        cmd.head_wdata = chm_pkg::NO_ENTRY;
        cmd.free_we    = ({1'b0, clr} < (chm_pkg::CLR_W + 1)'(chm_pkg::CAP));
        cmd.free_waddr = chm_pkg::SLOT_W'(clr);
        cmd.free_wdata = chm_pkg::SLOT_W'(chm_pkg::CAP - 1) - chm_pkg::SLOT_W'(clr);
      end
      S_ACT: begin
        if (req_q.mode == chm_pkg::MODE_PUT && found_q) begin
          cmd.val_we    = 1'b1;
          cmd.ent_waddr = hit[chm_pkg::SLOT_W-1:0];
        end else if (req_q.mode == chm_pkg::MODE_REMOVE && found_q) begin
          if (prev == chm_pkg::NO_ENTRY) begin
            cmd.head_we    = 1'b1;
            cmd.head_waddr = bucket_q;
            cmd.head_wdata = link_e;
          end else begin
            cmd.link_we   = 1'b1;
            cmd.ent_waddr = prev[chm_pkg::SLOT_W-1:0];
            cmd.ent_link  = link_e;
          end
          cmd.free_we    = (free_count < chm_pkg::IDX_W'(chm_pkg::CAP));
          cmd.free_waddr = free_count[chm_pkg::SLOT_W-1:0];
          cmd.free_wdata = hit[chm_pkg::SLOT_W-1:0];
        end
      end
      S_POP: begin
        cmd.key_we     = 1'b1;
        cmd.val_we     = 1'b1;
        cmd.link_we    = 1'b1;
        cmd.ent_waddr  = rd.free;
        cmd.ent_link   = head_val;
        cmd.head_we    = 1'b1;
        cmd.head_waddr = bucket_q;
        cmd.head_wdata = {1'b0, rd.free};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      free_count <= chm_pkg::IDX_W'(chm_pkg::CAP);
      key_count  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == chm_pkg::CLR_W'(chm_pkg::CLR_MAX - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            req_q    <= req;
            found_q  <= 1'b0;
            old_q    <= '0;
            status_q <= 1'b0;
            state    <= hash_start ? S_HASH : S_DONE;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bucket_q <= bucket;
            state    <= S_HEAD;
          end
        end
        S_HEAD: state <= S_HEADW;
        S_HEADW: begin
          cur      <= rd.head;
          head_val <= rd.head;
          prev     <= chm_pkg::NO_ENTRY;
          steps    <= '0;
          state    <= S_WALK;
        end
        S_WALK: begin
          if (cur >= chm_pkg::IDX_W'(chm_pkg::CAP) || steps == chm_pkg::IDX_W'(chm_pkg::CAP)) begin
            prev  <= chm_pkg::NO_ENTRY;
            state <= S_ACT;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd.key == req_q.key) begin
            found_q <= 1'b1;
            old_q   <= rd.val;
            hit     <= cur;
            link_e  <= rd.link;
            state   <= S_ACT;
          end else begin
            prev  <= cur;
            cur   <= rd.link;
            steps <= steps + 1'b1;
            state <= S_WALK;
          end
        end
        S_ACT: begin
          state <= S_DONE;
          if (req_q.mode == chm_pkg::MODE_PUT && !found_q) begin
            if (free_count == '0) status_q <= 1'b1;
            else state <= S_POP;
          end else if (req_q.mode == chm_pkg::MODE_REMOVE && found_q) begin
            if (free_count < chm_pkg::IDX_W'(chm_pkg::CAP)) free_count <= free_count + 1'b1;
            if (key_count != '0) key_count <= key_count - 1'b1;
          end
        end
        S_POP: begin
          free_count <= free_count - 1'b1;
          key_count  <= key_count + 1'b1;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp_valid       <= 1'b1;
            rsp.found       <= found_q;
            rsp.old_value   <= old_q;
            rsp.status      <= status_q;
            rsp.entry_total <= chm_pkg::TOTAL_W'(key_count);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHM_ASSERT(a_pool_balance, (state == S_CLEAR || (key_count + free_count == chm_pkg::IDX_W'(chm_pkg::CAP))), "keys and free entries do not add up to the pool")
  `CHM_ASSERT(a_one_at_a_time, (accept |=> !req_ready), "new request taken while one is in work")
  `CHM_ASSERT(a_refusal_only_full, (rsp_valid && rsp.status |-> rsp.entry_total == chm_pkg::TOTAL_W'(chm_pkg::CAP)), "put refused while the pool has room")
  `CHM_ASSERT_ALWAYS(a_clear_quiet, (state == S_CLEAR |-> !req_ready && !rsp_valid), "handshake active during clearing pass")

endmodule

FILE: src/chm_hash.sv
// Iterative FNV-1 64 hash unit: one multiply-xor round per cycle.
// Depends on chm_pkg.
`timescale 1ns / 1ps
module chm_hash (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [63:0]               key,
  output logic                      done,
  output logic [chm_pkg::BKT_W-1:0] bucket
);

  logic [63:0] h;
  logic [63:0] key_q;
  logic [2:0]  rnd;
  logic        run;
  logic [63:0] h_next;

  // Multiply by the prime as a shift plus a narrow product.
  assign h_next = ((h << chm_pkg::PRIME_SHIFT) + (h * {55'd0, chm_pkg::PRIME_LO}))
                  ^ {56'd0, key_q[{rnd, 3'b000} +: 8]};
  assign bucket = h[chm_pkg::BKT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        rnd   <= '0;
        h     <= chm_pkg::FNV_OFFSET;
        key_q <= key;
      end else if (run) begin
        h   <= h_next;
        rnd <= rnd + 3'd1;
        if (rnd == 3'(chm_pkg::HASH_ROUNDS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/chm_store.sv
// Memories of the hash map: bucket heads, entry key/value/link, free stack.
// Registered reads, one write port each. Depends on chm_pkg.
`timescale 1ns / 1ps
module chm_store (
  input  logic                clk,
  input  chm_pkg::store_cmd_t cmd,
  output chm_pkg::store_rd_t  rd
);

  logic [chm_pkg::IDX_W-1:0]  head_mem [chm_pkg::BUCKETS];
  logic [63:0]                key_mem  [chm_pkg::CAP];
  logic [63:0]                val_mem  [chm_pkg::CAP];
  logic [chm_pkg::IDX_W-1:0]  link_mem [chm_pkg::CAP];
  logic [chm_pkg::SLOT_W-1:0] free_mem [chm_pkg::CAP];

  logic [chm_pkg::IDX_W-1:0]  head_q;
  logic [63:0]                key_q;
  logic [63:0]                val_q;
  logic [chm_pkg::IDX_W-1:0]  link_q;
  logic [chm_pkg::SLOT_W-1:0] free_q;

  assign rd = {head_q, key_q, val_q, link_q, free_q};

  always_ff @(posedge clk) begin
    if (cmd.head_we) head_mem[cmd.head_waddr] <= cmd.head_wdata;
    head_q <= head_mem[cmd.head_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.key_we) key_mem[cmd.ent_waddr] <= cmd.ent_key;
    key_q <= key_mem[cmd.ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.val_we) val_mem[cmd.ent_waddr] <= cmd.ent_val;
    val_q <= val_mem[cmd.ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.link_we) link_mem[cmd.ent_waddr] <= cmd.ent_link;
    link_q <= link_mem[cmd.ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.free_we) free_mem[cmd.free_waddr] <= cmd.free_wdata;
    free_q <= free_mem[cmd.free_raddr];
  end

endmodule
